// ===== design/arc_pkg.sv =====
// Package for the auth response checker: phase and verdict types,
// message type codes and counter widths.
// Used by auth_response_checker_unit.
package arc_pkg;

  localparam int unsigned COUNT_BITS = 17;
  localparam int unsigned CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [7:0]  HDR_TYPE_A   = 8'h00;
  localparam logic [7:0]  HDR_TYPE_B   = 8'h02;
  localparam logic [15:0] MSG_AUTH     = 16'h0064;
  localparam logic [15:0] MSG_PROGRESS = 16'h000A;
  localparam logic [15:0] MSG_FAILED   = 16'h0065;

  typedef enum logic [1:0] {
    VERDICT_INVALID  = 2'd0,
    VERDICT_DENIED   = 2'd1,
    VERDICT_GRANTED  = 2'd2,
    VERDICT_PROGRESS = 2'd3
  } verdict_e;

  typedef enum logic [10:0] {
    PH_HDR      = 11'b000_0000_0001,
    PH_SLEN_LO  = 11'b000_0000_0010,
    PH_SLEN_HI  = 11'b000_0000_0100,
    PH_SSKIP    = 11'b000_0000_1000,
    PH_PSIZE_LO = 11'b000_0001_0000,
    PH_PSIZE_HI = 11'b000_0010_0000,
    PH_TYPE_LO  = 11'b000_0100_0000,
    PH_TYPE_HI  = 11'b000_1000_0000,
    PH_GRANT_LO = 11'b001_0000_0000,
    PH_GRANT_HI = 11'b010_0000_0000,
    PH_DONE     = 11'b100_0000_0000
  } phase_e;

  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// ===== design/auth_response_checker_unit.sv =====
// Auth response checker: parses a response frame one byte per transfer and
// gives one verdict per frame. Depends on arc_pkg.
// The verdict is registered into the output entry, or into the skid entry while the output entry is held.
// Throughput: one byte per cycle while in_ready_o is high; the parse state updates on each accepted byte.
// A two-entry result buffer keeps input ready while one verdict waits.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase
// and empties the result buffer.
module auth_response_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o
);

  arc_pkg::phase_e   phase_q, phase_d;
  logic [15:0]       str_left_q, str_left_d;
  logic [7:0]        low_hold_q, low_hold_d;
  logic [15:0]       declared_q, declared_d;
  arc_pkg::count_t   after_cnt_q, after_cnt_d;
  arc_pkg::verdict_e pending_q, pending_d;

  logic              out_valid_q, skid_valid_q;
  arc_pkg::verdict_e out_q, skid_q;

  logic              in_fire, push, pop;
  logic [15:0]       word;
  arc_pkg::verdict_e verdict_new;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push       = in_fire && frame_end_i;
  assign pop        = out_valid_q && out_ready_i;
  assign word       = {frame_byte_i, low_hold_q};

  always_comb begin
    phase_d     = phase_q;
    str_left_d  = str_left_q;
    low_hold_d  = low_hold_q;
    declared_d  = declared_q;
    after_cnt_d = after_cnt_q;
    pending_d   = pending_q;

    if (phase_q == arc_pkg::PH_TYPE_LO || phase_q == arc_pkg::PH_TYPE_HI ||
        phase_q == arc_pkg::PH_GRANT_LO || phase_q == arc_pkg::PH_GRANT_HI ||
        phase_q == arc_pkg::PH_DONE) begin
      if (after_cnt_q != '1) begin
        after_cnt_d = after_cnt_q + arc_pkg::count_t'(1);
      end
    end

    unique case (phase_q)
      arc_pkg::PH_HDR: begin
        if (frame_byte_i == arc_pkg::HDR_TYPE_A || frame_byte_i == arc_pkg::HDR_TYPE_B) begin
          phase_d = arc_pkg::PH_SLEN_LO;
        end else begin
          pending_d = arc_pkg::VERDICT_INVALID;
          phase_d   = arc_pkg::PH_DONE;
        end
      end
      arc_pkg::PH_SLEN_LO: begin
        low_hold_d = frame_byte_i;
        phase_d    = arc_pkg::PH_SLEN_HI;
      end
      arc_pkg::PH_SLEN_HI: begin
        str_left_d = word;
        phase_d    = (word == 16'd0) ? arc_pkg::PH_PSIZE_LO : arc_pkg::PH_SSKIP;
      end
      arc_pkg::PH_SSKIP: begin
        str_left_d = str_left_q - 16'd1;
        if (str_left_q == 16'd1) begin
          phase_d = arc_pkg::PH_PSIZE_LO;
        end
      end
      arc_pkg::PH_PSIZE_LO: begin
        low_hold_d = frame_byte_i;
        phase_d    = arc_pkg::PH_PSIZE_HI;
      end
      arc_pkg::PH_PSIZE_HI: begin
        declared_d = word;
        phase_d    = arc_pkg::PH_TYPE_LO;
      end
      arc_pkg::PH_TYPE_LO: begin
        low_hold_d = frame_byte_i;
        phase_d    = arc_pkg::PH_TYPE_HI;
      end
      arc_pkg::PH_TYPE_HI: begin
        phase_d = arc_pkg::PH_DONE;
        if (word == arc_pkg::MSG_AUTH) begin
          phase_d = arc_pkg::PH_GRANT_LO;
        end else if (word == arc_pkg::MSG_PROGRESS) begin
          pending_d = arc_pkg::VERDICT_PROGRESS;
        end else if (word == arc_pkg::MSG_FAILED) begin
          pending_d = arc_pkg::VERDICT_DENIED;
        end else begin
          pending_d = arc_pkg::VERDICT_INVALID;
        end
      end
      arc_pkg::PH_GRANT_LO: begin
        low_hold_d = frame_byte_i;
        phase_d    = arc_pkg::PH_GRANT_HI;
      end
      arc_pkg::PH_GRANT_HI: begin
        pending_d = (word != 16'd0) ? arc_pkg::VERDICT_GRANTED : arc_pkg::VERDICT_DENIED;
        phase_d   = arc_pkg::PH_DONE;
      end
      default: begin
        phase_d = arc_pkg::PH_DONE;
      end
    endcase
  end

  always_comb begin
    verdict_new = arc_pkg::VERDICT_INVALID;
    if (phase_d == arc_pkg::PH_DONE &&
        arc_pkg::CMP_BITS'(declared_d) >= arc_pkg::CMP_BITS'(after_cnt_d)) begin
      verdict_new = pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= arc_pkg::PH_HDR;
      str_left_q  <= '0;
      low_hold_q  <= '0;
      declared_q  <= '0;
      after_cnt_q <= '0;
      pending_q   <= arc_pkg::VERDICT_INVALID;
    end else if (in_fire) begin
      if (frame_end_i) begin
        phase_q     <= arc_pkg::PH_HDR;
        str_left_q  <= '0;
        low_hold_q  <= '0;
        declared_q  <= '0;
        after_cnt_q <= '0;
        pending_q   <= arc_pkg::VERDICT_INVALID;
      end else begin
        phase_q     <= phase_d;
        str_left_q  <= str_left_d;
        low_hold_q  <= low_hold_d;
        declared_q  <= declared_d;
        after_cnt_q <= after_cnt_d;
        pending_q   <= pending_d;
      end
    end
  end

  // The skid entry only fills while the output entry is held, so it always
  // holds the later of the two verdicts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= verdict_new;
        end
      end else if (push) begin
        out_q <= verdict_new;
      end
    end else if (push) begin
      skid_q <= verdict_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_q;

endmodule

// ===== design/arc_checker.sv =====
// Port-level checker for auth_response_checker_unit, attached by bind.
// Depends only on the top-level ports.
module arc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       frame_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] verdict_o
);

  // A stalled verdict holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o))
  else $error("stalled verdict changed or dropped");

  // Input back-pressure only happens while a verdict is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
  else $error("input stalled with no verdict pending");

  // The last byte of a frame always leaves a verdict valid on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> out_valid_o)
  else $error("frame end without verdict");

  // A byte that is not the last one creates no verdict from nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_ready_o && !(in_valid_i && frame_end_i) |=> !out_valid_o)
  else $error("verdict without frame end");

endmodule

bind auth_response_checker_unit arc_checker u_arc_checker (.*);
